@@ rtl/crd_pkg.sv @@
// Shared constants and types for the camera ray direction unit.
`default_nettype none
package crd_pkg;
  localparam int COMPONENT_BITS = 20;
  localparam int COORD_FRAC     = 28;
  localparam int NORM_LOW       = 29;
  localparam int NORM_HIGH      = 30;
  localparam int OUT_ONE        = 16384;
  localparam int OUT_BITS       = 16;
  localparam int INV_BITS       = 24;
  localparam int SAMPLE_BITS    = 16;
  localparam int MAG_BITS       = 30;
  localparam int SUM_BITS       = 62;
  localparam int LEN_BITS       = 31;
  localparam int NUM_BITS       = 45;
  localparam int SQRT_STEPS     = 31;
  localparam int DIV_STEPS      = 15;

  localparam logic [2:0] REG_RIGHT   = 3'd0;
  localparam logic [2:0] REG_UP      = 3'd1;
  localparam logic [2:0] REG_FORWARD = 3'd2;
  localparam logic [2:0] REG_INV_W   = 3'd3;
  localparam logic [2:0] REG_INV_H   = 3'd4;

  typedef struct packed {
    logic [MAG_BITS-1:0] mag;
    logic                neg;
  } comp_t;

  typedef struct packed {
    comp_t [2:0]         c;
    logic                zero;
    logic [SUM_BITS-1:0] rem;
    logic [LEN_BITS-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [2:0][NUM_BITS-1:0] num;
    logic [2:0][OUT_BITS-1:0] quo;
    logic [2:0]               neg;
    logic                     zero;
    logic [LEN_BITS-1:0]      len;
  } div_t;
endpackage
`default_nettype wire

@@ rtl/crd_front.sv @@
// Coordinate mapping, basis combination, normalising shift and sum-of-squares stages.
`default_nettype none
module crd_front #(
  parameter int COMPONENT_BITS = crd_pkg::COMPONENT_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [crd_pkg::SAMPLE_BITS-1:0] sample_x,
  input  wire logic [crd_pkg::SAMPLE_BITS-1:0] sample_y,
  input  wire logic [3*COMPONENT_BITS-1:0] right_basis,
  input  wire logic [3*COMPONENT_BITS-1:0] up_basis,
  input  wire logic [3*COMPONENT_BITS-1:0] forward_basis,
  input  wire logic [crd_pkg::INV_BITS-1:0] inverse_width,
  input  wire logic [crd_pkg::INV_BITS-1:0] inverse_height,
  output logic                             out_valid,
  output crd_pkg::sqrt_t                   out_data
);
  localparam int CW = 42;
  localparam int LW = 21;
  localparam int PL = COMPONENT_BITS + LW + 1;
  localparam int PH = COMPONENT_BITS + CW - LW;
  localparam int DW = CW + COMPONENT_BITS + 2;
  localparam int SW = 6;

  logic v1, v2, v3, v4, v5, v6;
  logic signed [CW-1:0] xx, yy;
  logic signed [PL-1:0] prl [3], pul [3];
  logic signed [PH-1:0] prh [3], puh [3];
  logic signed [DW-1:0] pf [3];
  logic signed [DW-1:0] d [3];
  logic [DW-1:0] dm [3];
  logic [2:0] dn;
  logic [DW-1:0] mx;
  logic [DW-1:0] am [3];
  logic [2:0] an;
  logic [DW-1:0] amx;
  logic [SW:0] lz;
  logic [crd_pkg::MAG_BITS-1:0] nm [3];
  logic [DW-1:0] sh;
  logic [crd_pkg::MAG_BITS-1:0] mg [3];
  logic [2:0] mn;
  logic mz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    xx <= $signed(CW'({sample_x, 1'b0}) * CW'(inverse_width))
          - (CW'(1) <<< crd_pkg::COORD_FRAC);
    yy <= $signed(CW'({sample_y, 1'b0}) * CW'(inverse_height))
          - (CW'(1) <<< crd_pkg::COORD_FRAC);
  end

  // split each coordinate into a low and a high half
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prl[k] <= $signed(right_basis[k*COMPONENT_BITS +: COMPONENT_BITS])
                * $signed({1'b0, xx[LW-1:0]});
      prh[k] <= $signed(right_basis[k*COMPONENT_BITS +: COMPONENT_BITS])
                * $signed(xx[CW-1:LW]);
      pul[k] <= $signed(up_basis[k*COMPONENT_BITS +: COMPONENT_BITS])
                * $signed({1'b0, yy[LW-1:0]});
      puh[k] <= $signed(up_basis[k*COMPONENT_BITS +: COMPONENT_BITS])
                * $signed(yy[CW-1:LW]);
      pf[k] <= DW'($signed(forward_basis[k*COMPONENT_BITS +: COMPONENT_BITS]))
               <<< crd_pkg::COORD_FRAC;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d[k] <= ((DW'(prh[k]) + DW'(puh[k])) <<< LW) + DW'(prl[k]) + DW'(pul[k])
              + pf[k];
    end
  end

  always_comb begin
    mx = '0;
    for (int k = 0; k < 3; k++) begin
      dn[k] = d[k][DW-1];
      dm[k] = dn[k] ? DW'(-d[k]) : DW'(d[k]);
      if (dm[k] > mx) mx = dm[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      am[k] <= dm[k];
    end
    an  <= dn;
    amx <= mx;
  end

  always_comb begin
    sh = '0;
    lz = '0;
    for (int b = 0; b < DW; b++) begin
      if (amx[b]) lz = (SW+1)'(b);
    end
    for (int k = 0; k < 3; k++) begin
      if (lz >= (SW+1)'(crd_pkg::MAG_BITS)) begin
        sh = am[k] >> (lz - (SW+1)'(crd_pkg::MAG_BITS - 1));
      end else begin
        sh = am[k] << ((SW+1)'(crd_pkg::MAG_BITS - 1) - lz);
      end
      nm[k] = sh[crd_pkg::MAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mg[k] <= nm[k];
    end
    mn <= an;
    mz <= (amx == '0);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      out_data.c[k].mag <= mg[k];
      out_data.c[k].neg <= mn[k];
    end
    out_data.zero <= mz;
    out_data.rem  <= 62'(mg[0]) * 62'(mg[0]) + 62'(mg[1]) * 62'(mg[1])
                     + 62'(mg[2]) * 62'(mg[2]);
    out_data.root <= '0;
  end

  assign out_valid = v6;
endmodule
`default_nettype wire

@@ rtl/crd_sqrt_cell.sv @@
// One digit cell of the pipelined integer square root.
`default_nettype none
module crd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  crd_pkg::sqrt_t      in_data,
  output logic                out_valid,
  output crd_pkg::sqrt_t      out_data
);
  localparam int SH = 2 * (crd_pkg::SQRT_STEPS - 1 - STEP);
  crd_pkg::sqrt_t nxt;
  logic [crd_pkg::SUM_BITS+1:0] trial;

  always_comb begin
    nxt = in_data;
    trial = (({2'b0, in_data.rem} >> SH) >= ({in_data.root, 2'b01}))
            ? ({2'b0, in_data.rem} - ({in_data.root, 2'b01} << SH)) : '1;
    if (trial != '1) begin
      nxt.rem  = trial[crd_pkg::SUM_BITS-1:0];
      nxt.root = {in_data.root[crd_pkg::LEN_BITS-2:0], 1'b1};
    end else begin
      nxt.root = {in_data.root[crd_pkg::LEN_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
  end
  always_ff @(posedge clk) out_data <= nxt;
endmodule
`default_nettype wire

@@ rtl/crd_div_cell.sv @@
// One quotient-bit cell of the three-lane restoring divider.
`default_nettype none
module crd_div_cell #(
  parameter int STEP = 0
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  crd_pkg::div_t  in_data,
  output logic           out_valid,
  output crd_pkg::div_t  out_data
);
  localparam int SH = crd_pkg::DIV_STEPS - 1 - STEP;
  crd_pkg::div_t nxt;
  logic [crd_pkg::NUM_BITS+SH:0] den;

  always_comb begin
    nxt = in_data;
    den = (crd_pkg::NUM_BITS+SH+1)'(in_data.len) << SH;
    for (int k = 0; k < 3; k++) begin
      if ((crd_pkg::NUM_BITS+SH+1)'(in_data.num[k]) >= den) begin
        nxt.num[k] = crd_pkg::NUM_BITS'((crd_pkg::NUM_BITS+SH+1)'(in_data.num[k]) - den);
        nxt.quo[k][SH] = 1'b1;
      end else begin
        nxt.quo[k][SH] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
  end
  always_ff @(posedge clk) out_data <= nxt;
endmodule
`default_nettype wire

@@ rtl/camera_ray_direction_unit.sv @@
// Top level of the pinhole camera ray direction unit.
// Accepts one sample per cycle whenever busy is low (busy stays low; the
// unit is fully pipelined). Each result appears with done high for one
// cycle; between the start transfer and the rise of done lie 6 front
// stages, 31 square-root cells, 1 divider load stage, 15 divider cells
// and the output register. The receiver cannot stall. Configure only
// while no sample is in flight.
`default_nettype none
module camera_ray_direction_unit #(
  parameter int COMPONENT_BITS = crd_pkg::COMPONENT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] sample_x,
  input  wire logic [15:0] sample_y,
  output logic             done,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic signed [15:0] dir_z,
  output logic             zero_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam int BW = 3 * COMPONENT_BITS;
  logic [BW-1:0] right_basis, up_basis, forward_basis;
  logic [23:0] inverse_width, inverse_height;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_basis <= '0; up_basis <= '0; forward_basis <= '0;
      inverse_width <= '0; inverse_height <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        crd_pkg::REG_RIGHT:   right_basis <= cfg_data[BW-1:0];
        crd_pkg::REG_UP:      up_basis <= cfg_data[BW-1:0];
        crd_pkg::REG_FORWARD: forward_basis <= cfg_data[BW-1:0];
        crd_pkg::REG_INV_W:   inverse_width <= cfg_data[23:0];
        crd_pkg::REG_INV_H:   inverse_height <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic sv [crd_pkg::SQRT_STEPS+1];
  crd_pkg::sqrt_t sd [crd_pkg::SQRT_STEPS+1];

  crd_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
    .clk, .rst, .in_valid(start & ~busy), .sample_x, .sample_y,
    .right_basis, .up_basis, .forward_basis, .inverse_width, .inverse_height,
    .out_valid(sv[0]), .out_data(sd[0])
  );

  for (genvar i = 0; i < crd_pkg::SQRT_STEPS; i++) begin : g_sqrt
    crd_sqrt_cell #(.STEP(i)) u_cell (
      .clk, .rst, .in_valid(sv[i]), .in_data(sd[i]),
      .out_valid(sv[i+1]), .out_data(sd[i+1])
    );
  end

  logic dv [crd_pkg::DIV_STEPS+1];
  crd_pkg::div_t dd [crd_pkg::DIV_STEPS+1];
  crd_pkg::sqrt_t s_last;
  logic [crd_pkg::LEN_BITS-1:0] len;
  logic div_in_valid;
  crd_pkg::div_t div_in;

  assign s_last = sd[crd_pkg::SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) div_in_valid <= 1'b0;
    else     div_in_valid <= sv[crd_pkg::SQRT_STEPS];
  end
  assign len = s_last.root;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      div_in.num[k] <= (crd_pkg::NUM_BITS'(s_last.c[k].mag) << 14)
                       + crd_pkg::NUM_BITS'(len >> 1);
      div_in.neg[k] <= s_last.c[k].neg;
      div_in.quo[k] <= '0;
    end
    div_in.zero <= s_last.zero;
    div_in.len  <= (len == '0) ? crd_pkg::LEN_BITS'(1) : len;
  end
  assign dv[0] = div_in_valid;
  assign dd[0] = div_in;

  for (genvar i = 0; i < crd_pkg::DIV_STEPS; i++) begin : g_div
    crd_div_cell #(.STEP(i)) u_cell (
      .clk, .rst, .in_valid(dv[i]), .in_data(dd[i]),
      .out_valid(dv[i+1]), .out_data(dd[i+1])
    );
  end

  crd_pkg::div_t dl;
  logic [15:0] q [3];
  logic [15:0] r [3];
  assign dl = dd[crd_pkg::DIV_STEPS];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q[k] = (dl.quo[k] > 16'(crd_pkg::OUT_ONE)) ? 16'(crd_pkg::OUT_ONE) : dl.quo[k];
      r[k] = dl.zero ? 16'd0 : (dl.neg[k] ? 16'(-q[k]) : q[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv[crd_pkg::DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    dir_x <= r[0]; dir_y <= r[1]; dir_z <= r[2];
    zero_length <= dl.zero;
  end
endmodule
`default_nettype wire

@@ rtl/crd_checker.sv @@
// Port-level checks for the camera ray direction unit, bound to the top level.
`default_nettype none
module crd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic done,
  input wire logic cfg_ready,
  input wire logic zero_length,
  input wire logic signed [15:0] dir_x,
  input wire logic signed [15:0] dir_y,
  input wire logic signed [15:0] dir_z
);
  a_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg_ready dropped");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && zero_length |-> dir_x == 0 && dir_y == 0 && dir_z == 0)
    else $error("zero vector gave nonzero output");
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> dir_x <= 16384 && dir_x >= -16384 && dir_y <= 16384 && dir_y >= -16384)
    else $error("direction out of range");
  a_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");
endmodule

bind camera_ray_direction_unit crd_checker u_crd_checker (
  .clk, .rst, .busy, .done, .cfg_ready, .zero_length, .dir_x, .dir_y, .dir_z
);
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the camera ray direction unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  typedef struct {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic               zl;
  } ray_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] sample_x = '0;
  logic [15:0] sample_y = '0;
  logic        done;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic        zero_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [59:0] right_q, up_q, fwd_q;
  logic [23:0] inv_w_q, inv_h_q;

  ray_t  rays_pending[$];
  bit    failed = 0;
  bit    no_idle = 0;
  int    stall_cycles = 0;

  camera_ray_direction_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample_x(sample_x), .sample_y(sample_y), .done(done),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .zero_length(zero_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint basis_comp(logic [59:0] p, int k);
    logic signed [19:0] r;
    r = p[k*20 +: 20];
    return longint'(r);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic ray_t trace_ray(logic [15:0] sx, logic [15:0] sy);
    ray_t r;
    longint xx, yy, d;
    longint unsigned mag[3];
    bit neg[3];
    longint unsigned maxm, sum, len, q;
    logic [15:0] o[3];
    xx = longint'(64'd2 * 64'(sx) * 64'(inv_w_q))
         - (longint'(1) << crd_pkg::COORD_FRAC);
    yy = longint'(64'd2 * 64'(sy) * 64'(inv_h_q))
         - (longint'(1) << crd_pkg::COORD_FRAC);
    maxm = 0;
    for (int k = 0; k < 3; k++) begin
      d = basis_comp(right_q, k) * xx + basis_comp(up_q, k) * yy
        + basis_comp(fwd_q, k) * (longint'(1) << crd_pkg::COORD_FRAC);
      neg[k] = d < 0;
      mag[k] = neg[k] ? longint'(0) - d : d;
      if (mag[k] > maxm) maxm = mag[k];
    end
    if (maxm == 0) begin
      r.dx = 0; r.dy = 0; r.dz = 0; r.zl = 1'b1;
      return r;
    end
    while (maxm >= (64'd1 << crd_pkg::NORM_HIGH)) begin
      maxm = maxm >> 1;
      for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
    end
    while (maxm < (64'd1 << crd_pkg::NORM_LOW)) begin
      maxm = maxm << 1;
      for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
    end
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = floor_root(sum);
    for (int k = 0; k < 3; k++) begin
      q = (mag[k] * crd_pkg::OUT_ONE + len / 2) / len;
      if (q > crd_pkg::OUT_ONE) q = crd_pkg::OUT_ONE;
      o[k] = neg[k] ? 16'(64'd0 - q) : 16'(q);
    end
    r.dx = o[0]; r.dy = o[1]; r.dz = o[2]; r.zl = 1'b0;
    return r;
  endfunction

  // sample handshakes away from the driving edge
  always @(negedge clk) begin
    ray_t e;
    if (!rst) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles > 5000) begin
        $display("FAIL");
        $finish;
      end
      if (done) begin
        if (rays_pending.size() == 0) begin
          $error("result with nothing expected");
          failed = 1;
        end else begin
          e = rays_pending.pop_front();
          if (dir_x !== e.dx) begin
            $error("dir_x expected %0d actual %0d", e.dx, dir_x); failed = 1;
          end
          if (dir_y !== e.dy) begin
            $error("dir_y expected %0d actual %0d", e.dy, dir_y); failed = 1;
          end
          if (dir_z !== e.dz) begin
            $error("dir_z expected %0d actual %0d", e.dz, dir_z); failed = 1;
          end
          if (zero_length !== e.zl) begin
            $error("zero_length expected %0d actual %0d", e.zl, zero_length);
            failed = 1;
          end
        end
      end
    end
  end

  task automatic drain();
    start <= 1'b0;
    while (rays_pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    bit acc;
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk) acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    case (idx)
      crd_pkg::REG_RIGHT:   right_q = val[59:0];
      crd_pkg::REG_UP:      up_q    = val[59:0];
      crd_pkg::REG_FORWARD: fwd_q   = val[59:0];
      crd_pkg::REG_INV_W:   inv_w_q = val[23:0];
      crd_pkg::REG_INV_H:   inv_h_q = val[23:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(logic [15:0] sx, logic [15:0] sy);
    bit acc;
    while (!no_idle && $urandom_range(99) < 25) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    sample_x <= sx;
    sample_y <= sy;
    do begin
      @(negedge clk) acc = !busy;
      @(posedge clk);
    end while (!acc);
    rays_pending = {rays_pending, trace_ray(sx, sy)};
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic set_all(logic [63:0] r, logic [63:0] u, logic [63:0] f,
                         logic [63:0] iw, logic [63:0] ih);
    write_reg(crd_pkg::REG_RIGHT, r);
    write_reg(crd_pkg::REG_UP, u);
    write_reg(crd_pkg::REG_FORWARD, f);
    write_reg(crd_pkg::REG_INV_W, iw);
    write_reg(crd_pkg::REG_INV_H, ih);
  endtask

  task automatic test_reset_zero();
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_bad_index();
    write_reg(3'd5, rand64());
    write_reg(3'd6, rand64());
    write_reg(3'd7, '1);
    send_sample(16'h1234, 16'hFEDC);
  endtask

  task automatic test_directed();
    // typical camera: right +x, up +y, forward -z, 640 x 480
    set_all({4'hF, 20'h0, 20'h0, 20'h10000}, {4'hA, 20'h0, 20'h10000, 20'h0},
            {4'h5, 20'hF0000, 20'h0, 20'h0}, 64'd26214, 64'd34953);
    send_sample(16'd0, 16'd0);
    send_sample(16'd10240, 16'd7680);
    send_sample(16'd5120, 16'd3840);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h0000, 16'hFFFF);
    // exact cancellation gives a zero vector
    set_all(64'h10000, 64'h0, 64'h0, 64'h800000, 64'h0);
    send_sample(16'd16, 16'd0);
    send_sample(16'd17, 16'd0);
    // extremes of the registers
    set_all('1, '1, '1, '1, '1);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h0000, 16'h0000);
    set_all({3{20'h7FFFF}}, {3{20'h80000}}, {3{20'h7FFFF}}, 64'hFFFFFF, 64'h0);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h8000, 16'h0001);
    set_all({3{20'h80000}}, {3{20'h80000}}, {3{20'h80000}}, 64'h0, 64'hFFFFFF);
    send_sample(16'hFFFF, 16'hAAAA);
    send_sample(16'h5555, 16'h0000);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 0)
        set_all(rand64(), rand64(), rand64(), rand64(), rand64());
      else
        set_all({4'h0, 20'($signed($urandom_range(0, 262143)) - 131072),
                 20'($urandom_range(0, 1023)), 20'($urandom_range(0, 131072))},
                {4'h0, 20'($urandom_range(0, 1023)), 20'($urandom_range(0, 131072)),
                 20'($urandom_range(0, 1023))},
                {4'h0, 20'($signed($urandom_range(0, 262143)) - 131072),
                 20'($urandom_range(0, 4095)), 20'($urandom_range(0, 4095))},
                64'($urandom_range(1, 16777215) >> $urandom_range(0, 14)),
                64'($urandom_range(1, 16777215) >> $urandom_range(0, 14)));
      no_idle = (ph == 4);
      for (int i = 0; i < 102; i++) begin
        if (ph == 7 && i == 50) drain();
        send_sample(16'($urandom()), 16'($urandom()));
      end
    end
    no_idle = 0;
  endtask

  initial begin
    right_q = '0; up_q = '0; fwd_q = '0; inv_w_q = '0; inv_h_q = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_zero();
    test_bad_index();
    test_directed();
    test_random();
    drain();
    if (!failed) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
